[design/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg: shared types and helpers for the MNA stamp engine
// Sizes, codes, the front-to-back command beat and saturating arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package mse_pkg;

	localparam int MAX_NODES    = 64;
	localparam int MAX_BRANCHES = 32;
	localparam int DIM          = MAX_NODES + MAX_BRANCHES;
	localparam int MAT_DEPTH    = DIM * DIM;

	localparam int NODE_W  = 7;
	localparam int BR_W    = 6;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 3;
	localparam int VAL_W   = 32;
	localparam int ENT_W   = 48;
	localparam int CFG_W   = 7;
	localparam int IDX_W   = $clog2(DIM);
	localparam int ADDR_W  = $clog2(MAT_DEPTH);
	localparam int QUO_W   = VAL_W + 1;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);

	localparam int STEP_COUNT = 5;
	localparam int STEP_W     = $clog2(STEP_COUNT + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ENT_W-1:0] UNIT = ENT_W'(65536);

	localparam logic CFG_NODE_COUNT   = 1'b0;
	localparam logic CFG_BRANCH_COUNT = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		K_RES  = 3'd0,
		K_ISRC = 3'd1,
		K_VSRC = 3'd2,
		K_IND  = 3'd3,
		K_CAP  = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_NODE  = 3'd1,
		ST_ZERO_R    = 3'd2,
		ST_NO_BRANCH = 3'd3,
		ST_BAD_READ  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_READ, OP_RES, OP_CAP, OP_ISRC, OP_VSRC, OP_IND
	} op_t;

	typedef enum logic [1:0] {
		T_NONE, T_COND, T_STORE, T_SRC
	} target_t;

	typedef enum logic [1:0] {
		F_IDLE, F_DIV, F_PUSH
	} fstate_t;

	typedef enum logic [2:0] {
		B_CLR, B_IDLE, B_STEP, B_WR, B_OUT
	} bstate_t;

	typedef struct packed {
		op_t               op;
		status_t           status;
		logic [NODE_W-1:0] p;
		logic [NODE_W-1:0] n;
		logic [IDX_W-1:0]  k;
		logic [IDX_W-1:0]  rr;
		logic [IDX_W-1:0]  rc;
		logic [ENT_W-1:0]  value;
		logic [BR_W-1:0]   br_used;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic logic [ENT_W-1:0] sat_add(input logic [ENT_W-1:0] a,
		input logic [ENT_W-1:0] b);
		logic [ENT_W:0] s;
		s = {a[ENT_W-1], a} + {b[ENT_W-1], b};
		if (s[ENT_W] != s[ENT_W-1])
			return s[ENT_W] ? {1'b1, {(ENT_W-1){1'b0}}} : {1'b0, {(ENT_W-1){1'b1}}};
		return s[ENT_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);
	endfunction

endpackage
`default_nettype wire

[design/mse_ifs.sv]
// ----------------------------------------------------------------------------
// mse_ifs: channel interfaces of the MNA stamp engine
// Item input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface mse_in_if;
	logic               valid;
	logic               ready;
	logic [0:0]         cmd;
	logic [2:0]         element_kind;
	logic [6:0]         plus_node;
	logic [6:0]         minus_node;
	logic signed [31:0] element_value;
	logic [6:0]         read_row;
	logic [6:0]         read_col;
	modport source (output valid, cmd, element_kind, plus_node, minus_node,
		element_value, read_row, read_col, input ready);
	modport sink (input valid, cmd, element_kind, plus_node, minus_node,
		element_value, read_row, read_col, output ready);
endinterface

interface mse_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] cond_entry;
	logic signed [47:0] store_entry;
	logic signed [47:0] source_entry;
	logic [5:0]         branches_used;
	logic [2:0]         status;
	modport source (output valid, cond_entry, store_entry, source_entry,
		branches_used, status, input ready);
	modport sink (input valid, cond_entry, store_entry, source_entry,
		branches_used, status, output ready);
endinterface

interface mse_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/mse_front.sv]
// ----------------------------------------------------------------------------
// mse_front: item intake and classification
// Holds the registers and branch counter, checks each item, computes the
// conductance with a bit-serial divider and hands a command beat to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module mse_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mse_in_if.sink                 in_ch,
	mse_cfg_if.sink                cfg,
	input  wire mse_pkg::back_stat_t bstat,
	input  wire logic              q_full,
	output logic                   push,
	output mse_pkg::cmd_t          push_cmd
);
	import mse_pkg::*;

	fstate_t              fst_q, fst_d;
	logic [NODE_W-1:0]    node_count_q;
	logic [BR_W-1:0]      branch_count_q;
	logic [BR_W-1:0]      brcnt_q;
	cmd_t                 cmd_q, cls;
	logic                 alloc, need_div, accept;
	logic [NODE_W-1:0]    nodes;
	logic [BR_W-1:0]      brs;
	logic [NODE_W:0]      size;
	logic [VAL_W-1:0]     dsr_q, absval;
	logic                 neg_q;
	logic [QUO_W-1:0]     rem_q, dvd_q, quo_q, rem_sh, quo_next;
	logic [QUO_W:0]       diff;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ENT_W-1:0]     quo_ext;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (fst_q == F_IDLE) && !bstat.clearing;
	assign accept      = in_ch.valid && in_ch.ready;
	assign push        = (fst_q == F_PUSH) && !q_full;
	assign push_cmd    = cmd_q;

	always_comb begin
		nodes = (node_count_q > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_q;
		brs   = (branch_count_q > BR_W'(MAX_BRANCHES)) ? BR_W'(MAX_BRANCHES) : branch_count_q;
		size  = (NODE_W+1)'(nodes) + (NODE_W+1)'(brs);
		alloc    = 1'b0;
		need_div = 1'b0;
		cls        = '0;
		cls.op     = OP_NONE;
		cls.status = ST_OK;
		cls.p      = in_ch.plus_node;
		cls.n      = in_ch.minus_node;
		cls.rr     = IDX_W'(in_ch.read_row);
		cls.rc     = IDX_W'(in_ch.read_col);
		cls.k      = IDX_W'(nodes) + IDX_W'(brcnt_q);
		cls.value  = {{(ENT_W-VAL_W){in_ch.element_value[VAL_W-1]}}, in_ch.element_value};
		if (in_ch.cmd[0]) begin
			if ((NODE_W+1)'(in_ch.read_row) >= size || (NODE_W+1)'(in_ch.read_col) >= size)
				cls.status = ST_BAD_READ;
			else
				cls.op = OP_READ;
		end else if (in_ch.plus_node > nodes || in_ch.minus_node > nodes) begin
			cls.status = ST_BAD_NODE;
		end else begin
			unique case (kind_t'(in_ch.element_kind))
				K_RES: begin
					if (in_ch.element_value == '0) begin
						cls.status = ST_ZERO_R;
					end else begin
						cls.op   = OP_RES;
						need_div = 1'b1;
					end
				end
				K_ISRC: cls.op = OP_ISRC;
				K_VSRC, K_IND: begin
					if (brcnt_q >= brs) begin
						cls.status = ST_NO_BRANCH;
					end else begin
						cls.op = (kind_t'(in_ch.element_kind) == K_VSRC) ? OP_VSRC : OP_IND;
						alloc  = 1'b1;
					end
				end
				K_CAP: cls.op = OP_CAP;
				default: cls.op = OP_NONE;
			endcase
		end
		cls.br_used = brcnt_q + BR_W'(alloc);
		absval = in_ch.element_value[VAL_W-1] ? (~in_ch.element_value + 1'b1)
			: in_ch.element_value;
	end

	always_comb begin
		rem_sh   = {rem_q[QUO_W-2:0], dvd_q[QUO_W-1]};
		diff     = {1'b0, rem_sh} - {2'b00, dsr_q};
		quo_next = {quo_q[QUO_W-2:0], !diff[QUO_W]};
		quo_ext  = ENT_W'(quo_next);
	end

	always_comb begin
		fst_d = fst_q;
		unique case (fst_q)
			F_IDLE: if (accept) fst_d = need_div ? F_DIV : F_PUSH;
			F_DIV:  if (cnt_q == DIV_CNT_W'(1)) fst_d = F_PUSH;
			F_PUSH: if (!q_full) fst_d = F_IDLE;
			default: fst_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q          <= F_IDLE;
			node_count_q   <= '0;
			branch_count_q <= '0;
			brcnt_q        <= '0;
		end else begin
			fst_q <= fst_d;
			if (cfg.valid) begin
				unique case (cfg.index[0])
					CFG_NODE_COUNT:   node_count_q   <= cfg.data;
					CFG_BRANCH_COUNT: branch_count_q <= cfg.data[BR_W-1:0];
					default: ;
				endcase
			end
			if (accept)
				brcnt_q <= brcnt_q + BR_W'(alloc);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cls;
			dsr_q <= absval;
			neg_q <= in_ch.element_value[VAL_W-1];
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= {1'b1, {(QUO_W-1){1'b0}}};
			cnt_q <= DIV_CNT_W'(QUO_W);
		end else if (fst_q == F_DIV) begin
			rem_q <= diff[QUO_W] ? rem_sh : diff[QUO_W-1:0];
			quo_q <= quo_next;
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1))
				cmd_q.value <= neg_q ? (~quo_ext + 1'b1) : quo_ext;
		end
	end

endmodule
`default_nettype wire

[design/mse_queue.sv]
// ----------------------------------------------------------------------------
// mse_queue: command queue between front and back
// Two-entry first-in first-out buffer of command beats.
// ----------------------------------------------------------------------------
`default_nettype none
module mse_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mse_pkg::cmd_t din,
	input  wire logic          pop,
	output mse_pkg::cmd_t      dout,
	output logic               full,
	output logic               empty
);
	import mse_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

endmodule
`default_nettype wire

[design/mse_back.sv]
// ----------------------------------------------------------------------------
// mse_back: stamp execution
// Owns the matrices and source vector, clears them after reset, runs the
// read-modify-write steps of each command and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module mse_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire mse_pkg::cmd_t head,
	output logic               pop,
	output mse_pkg::back_stat_t bstat,
	mse_out_if.source          out_ch
);
	import mse_pkg::*;

	logic [ENT_W-1:0]  cond_mem  [MAT_DEPTH];
	logic [ENT_W-1:0]  store_mem [MAT_DEPTH];
	logic [ENT_W-1:0]  src_mem   [DIM];
	logic [ENT_W-1:0]  cond_rd_q, store_rd_q, src_rd_q;

	bstate_t           bst_q, bst_d;
	cmd_t              cur_q;
	logic [STEP_W-1:0] idx_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ENT_W-1:0]  ce_q, se_q, ve_q;

	logic              out_valid_q;
	logic [ENT_W-1:0]  out_ce_q, out_se_q, out_ve_q;
	logic [BR_W-1:0]   out_br_q;
	status_t           out_st_q;

	target_t           tgt;
	logic [IDX_W-1:0]  row, col, pi, ni;
	logic [ENT_W-1:0]  addend, negv, rd_sel, wdata;
	logic              en, set_mode, pz, nz, clearing, wr, load_out;
	logic [ADDR_W-1:0] maddr;
	logic [IDX_W-1:0]  saddr;

	assign clearing       = (bst_q == B_CLR);
	assign bstat.clearing = clearing;
	assign pop            = (bst_q == B_IDLE) && !q_empty;
	assign wr             = (bst_q == B_WR);
	assign load_out       = (bst_q == B_OUT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		pi       = IDX_W'(cur_q.p - 1'b1);
		ni       = IDX_W'(cur_q.n - 1'b1);
		pz       = (cur_q.p != '0);
		nz       = (cur_q.n != '0);
		negv     = ~cur_q.value + 1'b1;
		tgt      = T_NONE;
		row      = '0;
		col      = '0;
		addend   = '0;
		en       = 1'b0;
		set_mode = 1'b0;
		unique case (cur_q.op)
			OP_RES, OP_CAP: begin
				tgt = (cur_q.op == OP_RES) ? T_COND : T_STORE;
				case (idx_q)
					STEP_W'(0): begin row = pi; col = pi; addend = cur_q.value; en = pz; end
					STEP_W'(1): begin row = ni; col = ni; addend = cur_q.value; en = nz; end
					STEP_W'(2): begin row = pi; col = ni; addend = negv; en = pz && nz; end
					STEP_W'(3): begin row = ni; col = pi; addend = negv; en = pz && nz; end
					default: en = 1'b0;
				endcase
			end
			OP_ISRC: begin
				tgt = T_SRC;
				case (idx_q)
					STEP_W'(0): begin row = pi; addend = negv; en = pz; end
					STEP_W'(1): begin row = ni; addend = cur_q.value; en = nz; end
					default: en = 1'b0;
				endcase
			end
			OP_VSRC, OP_IND: begin
				tgt = T_COND;
				case (idx_q)
					STEP_W'(0): begin row = pi; col = cur_q.k; addend = UNIT; en = pz; end
					STEP_W'(1): begin row = cur_q.k; col = pi; addend = UNIT; en = pz; end
					STEP_W'(2): begin row = ni; col = cur_q.k; addend = ~UNIT + 1'b1; en = nz; end
					STEP_W'(3): begin row = cur_q.k; col = ni; addend = ~UNIT + 1'b1; en = nz; end
					STEP_W'(4): begin
						row = cur_q.k;
						col = cur_q.k;
						en  = 1'b1;
						if (cur_q.op == OP_VSRC) begin
							tgt    = T_SRC;
							addend = cur_q.value;
						end else begin
							tgt      = T_STORE;
							addend   = negv;
							set_mode = 1'b1;
						end
					end
					default: en = 1'b0;
				endcase
			end
			OP_READ: begin
				row = cur_q.rr;
				col = cur_q.rc;
				en  = (idx_q == '0);
			end
			default: en = 1'b0;
		endcase
	end

	always_comb begin
		maddr = clearing ? clr_q : mat_addr(row, col);
		saddr = clearing ? clr_q[IDX_W-1:0] : row;
		case (tgt)
			T_COND:  rd_sel = cond_rd_q;
			T_STORE: rd_sel = store_rd_q;
			T_SRC:   rd_sel = src_rd_q;
			default: rd_sel = '0;
		endcase
		if (clearing)
			wdata = '0;
		else if (set_mode)
			wdata = addend;
		else
			wdata = sat_add(rd_sel, addend);
	end

	always_ff @(posedge clk) begin
		if (clearing || (wr && tgt == T_COND))
			cond_mem[maddr] <= wdata;
		if (clearing || (wr && tgt == T_STORE))
			store_mem[maddr] <= wdata;
		if ((clearing && clr_q < ADDR_W'(DIM)) || (wr && tgt == T_SRC))
			src_mem[saddr] <= wdata;
		cond_rd_q  <= cond_mem[maddr];
		store_rd_q <= store_mem[maddr];
		src_rd_q   <= src_mem[saddr];
	end

	always_comb begin
		bst_d = bst_q;
		unique case (bst_q)
			B_CLR:  if (clr_q == ADDR_W'(MAT_DEPTH - 1)) bst_d = B_IDLE;
			B_IDLE: if (!q_empty) bst_d = B_STEP;
			B_STEP: begin
				if (idx_q == STEP_W'(STEP_COUNT))
					bst_d = B_OUT;
				else if (en)
					bst_d = B_WR;
			end
			B_WR:   bst_d = B_STEP;
			B_OUT:  if (load_out) bst_d = B_IDLE;
			default: bst_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			bst_q <= bst_d;
			if (clearing)
				clr_q <= clr_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			idx_q <= '0;
			ce_q  <= '0;
			se_q  <= '0;
			ve_q  <= '0;
		end else if ((bst_q == B_STEP && !en && idx_q != STEP_W'(STEP_COUNT)) || wr) begin
			idx_q <= idx_q + 1'b1;
		end
		if (wr && cur_q.op == OP_READ) begin
			ce_q <= cond_rd_q;
			se_q <= store_rd_q;
			ve_q <= src_rd_q;
		end
		if (load_out) begin
			out_ce_q <= ce_q;
			out_se_q <= se_q;
			out_ve_q <= ve_q;
			out_br_q <= cur_q.br_used;
			out_st_q <= cur_q.status;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.cond_entry    = out_ce_q;
	assign out_ch.store_entry   = out_se_q;
	assign out_ch.source_entry  = out_ve_q;
	assign out_ch.branches_used = out_br_q;
	assign out_ch.status        = out_st_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != ST_OK) |->
			(out_ce_q == '0 && out_se_q == '0 && out_ve_q == '0))
		else $error("error result carries nonzero entries");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("command taken during clearing pass");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(bst_q == B_OUT))
		else $error("result beat raised outside output state");

endmodule
`default_nettype wire

[design/mna_stamp_engine.sv]
// ----------------------------------------------------------------------------
// mna_stamp_engine: modified nodal analysis stamp engine
// Accumulates element stamps into conductance, storage and source stores and
// answers entry reads, in saturating Q32.16.
//
// Usage:
//   cfg    : register writes (index 0 node_count, 1 branch_count), always ready.
//   in_ch  : one beat per element stamp or entry read.
//   out_ch : exactly one result beat per input beat, in order.
// After reset the stores are cleared one address per cycle, all 9216 of them,
// while in_ch.ready stays low; register writes are taken meanwhile.
// Result latency depends on the item kind. The bit-serial reciprocal divider
// in the front part and the back's single store port (a read, then a write,
// per active read-modify-write step; a skipped step only advances) set it. The
// front takes a new item only after its last command beat enters the queue;
// the back takes the next command once its result is loaded. A two-entry
// command queue joins the parts and results wait in an output register; a
// stalled receiver holds the back part while the front keeps accepting until
// the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none
module mna_stamp_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	mse_in_if.sink    in_ch,
	mse_cfg_if.sink   cfg,
	mse_out_if.source out_ch
);
	import mse_pkg::*;

	cmd_t       push_cmd, head;
	logic       push, pop, q_full, q_empty;
	back_stat_t bstat;

	mse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.bstat    (bstat),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	mse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.bstat   (bstat),
		.out_ch  (out_ch)
	);

endmodule
`default_nettype wire
